[sv/nsc_pkg.sv]
// Shared constants, types and helpers for the NMEA sentence checksum framer.
`timescale 1ns / 1ps

package nsc_pkg;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;

    typedef enum logic [2:0] {
        CAUSE_OK       = 3'd0,
        CAUSE_OVERFLOW = 3'd1,
        CAUSE_NO_DOLLAR = 3'd2,
        CAUSE_NO_STAR  = 3'd3,
        CAUSE_NON_HEX  = 3'd4,
        CAUSE_MISMATCH = 3'd5
    } t_cause;

    typedef struct packed {
        logic       sentence_ok;
        t_cause     reject_cause;
        logic [7:0] computed_sum;
        logic [7:0] received_sum;
    } t_verdict;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } t_nibble;

    // Hex digit decode, either case; non-hex gives value zero.
    function automatic t_nibble hex_nibble(input logic [7:0] c);
        t_nibble n;
        n.is_hex = 1'b1;
        n.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            n.value = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            n.value = c[3:0] + 4'd9;
        end else begin
            n.is_hex = 1'b0;
        end
        return n;
    endfunction

endpackage

[sv/nsc_line.sv]
// Per-line tracking: length, framing flags, running XOR, tail digits and verdict.
`timescale 1ns / 1ps

module nsc_line import nsc_pkg::*; #(
    parameter int LINE_CAPACITY = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    output logic       o_eol,
    output t_verdict   o_verdict
);

    localparam int LEN_W = $clog2(LINE_CAPACITY);
    localparam logic [LEN_W-1:0] CAP_LAST = LEN_W'(LINE_CAPACITY - 1);

    logic [LEN_W-1:0] r_len,    n_len;
    logic             r_over,   n_over;
    logic             r_dollar, n_dollar;
    logic             r_star,   n_star;
    logic [7:0]       r_xor,    n_xor;
    logic [1:0]       r_tail,   n_tail;
    logic [7:0]       r_digits, n_digits;
    logic             r_hex,    n_hex;

    t_nibble nib;
    t_cause  cause;

    assign nib   = hex_nibble(i_rx_byte);
    assign o_eol = (i_rx_byte == CH_NEWLINE);

    always_comb begin
        n_len    = r_len;
        n_over   = r_over;
        n_dollar = r_dollar;
        n_star   = r_star;
        n_xor    = r_xor;
        n_tail   = r_tail;
        n_digits = r_digits;
        n_hex    = r_hex;
        if (i_accept) begin
            if (o_eol) begin
                n_len    = '0;
                n_over   = 1'b0;
                n_dollar = 1'b0;
                n_star   = 1'b0;
                n_xor    = 8'd0;
                n_tail   = 2'd0;
                n_digits = 8'd0;
                n_hex    = 1'b1;
            end else if (!r_over) begin
                if (r_len == CAP_LAST) begin
                    n_over = 1'b1;
                end else begin
                    n_len = r_len + 1'b1;
                    if (r_len == '0) begin
                        n_dollar = (i_rx_byte == CH_DOLLAR);
                        n_star   = (i_rx_byte == CH_STAR);
                    end else if (!r_star) begin
                        if (i_rx_byte == CH_STAR) begin
                            n_star = 1'b1;
                        end else begin
                            n_xor = r_xor ^ i_rx_byte;
                        end
                    end else if (r_tail != 2'd2) begin
                        n_digits = {r_digits[3:0], nib.value};
                        n_tail   = r_tail + 2'd1;
                        if (!nib.is_hex) begin
                            n_hex = 1'b0;
                        end
                    end
                end
            end
        end
    end

    // First cause that applies, in priority order.
    always_comb begin
        if (r_over) begin
            cause = CAUSE_OVERFLOW;
        end else if (!r_dollar) begin
            cause = CAUSE_NO_DOLLAR;
        end else if (!r_star || r_tail != 2'd2) begin
            cause = CAUSE_NO_STAR;
        end else if (!r_hex) begin
            cause = CAUSE_NON_HEX;
        end else if (r_digits != r_xor) begin
            cause = CAUSE_MISMATCH;
        end else begin
            cause = CAUSE_OK;
        end
    end

    always_comb begin
        o_verdict.sentence_ok  = (cause == CAUSE_OK);
        o_verdict.reject_cause = cause;
        o_verdict.computed_sum = r_xor;
        o_verdict.received_sum = (cause == CAUSE_OK || cause == CAUSE_MISMATCH) ?
                                 r_digits : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_over   <= 1'b0;
            r_dollar <= 1'b0;
            r_star   <= 1'b0;
            r_xor    <= 8'd0;
            r_tail   <= 2'd0;
            r_digits <= 8'd0;
            r_hex    <= 1'b1;
        end else begin
            r_len    <= n_len;
            r_over   <= n_over;
            r_dollar <= n_dollar;
            r_star   <= n_star;
            r_xor    <= n_xor;
            r_tail   <= n_tail;
            r_digits <= n_digits;
            r_hex    <= n_hex;
        end
    end

endmodule

[sv/nsc_out.sv]
// Result register with good/bad totals and the output transfer handshake.
`timescale 1ns / 1ps

module nsc_out import nsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_verdict    i_verdict,
    input  logic        i_stall,
    output logic        o_busy,
    output logic        o_valid,
    output t_verdict    o_verdict,
    output logic [31:0] o_good_total,
    output logic [31:0] o_bad_total
);

    logic        r_valid;
    t_verdict    r_verdict;
    logic [31:0] r_good, n_good;
    logic [31:0] r_bad,  n_bad;

    // Result register cannot take a new result while holding a stalled one.
    assign o_busy = r_valid && i_stall;

    always_comb begin
        n_good = r_good;
        n_bad  = r_bad;
        if (i_load) begin
            if (i_verdict.sentence_ok) begin
                n_good = r_good + 32'd1;
            end else begin
                n_bad = r_bad + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_good  <= 32'd0;
            r_bad   <= 32'd0;
        end else begin
            r_good <= n_good;
            r_bad  <= n_bad;
            if (!o_busy) begin
                r_valid <= i_load;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_verdict <= i_verdict;
        end
    end

    assign o_valid      = r_valid;
    assign o_verdict    = r_verdict;
    assign o_good_total = r_good;
    assign o_bad_total  = r_bad;

endmodule

[sv/nmea_sentence_checksum_framer.sv]
// Top level of the NMEA sentence checksum framer.
`timescale 1ns / 1ps

// Takes one received serial byte per transfer and frames lines ending in
// newline. Each newline yields one result in the next cycle: the verdict, the
// reject cause, the computed XOR, the received hex sum and the running good and
// bad totals (wrapping at 2^32). Other bytes yield no result. One byte is taken
// every cycle; the input stalls only while a finished result is held stalled in
// the output register. Lines longer than LINE_CAPACITY-1 bytes are rejected as
// overflowed; bytes beyond that are dropped until the newline.

module nmea_sentence_checksum_framer import nsc_pkg::*; #(
    parameter int LINE_CAPACITY = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_sentence_ok,
    output logic [2:0]  o_reject_cause,
    output logic [7:0]  o_computed_sum,
    output logic [7:0]  o_received_sum,
    output logic [31:0] o_good_total,
    output logic [31:0] o_bad_total
);

    logic     accept;
    logic     eol;
    logic     busy;
    t_verdict line_verdict;
    t_verdict out_verdict;

    assign o_stall = busy;
    assign accept  = i_valid && !busy;

    nsc_line #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_line (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_eol     (eol),
        .o_verdict (line_verdict)
    );

    nsc_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept && eol),
        .i_verdict    (line_verdict),
        .i_stall      (i_stall),
        .o_busy       (busy),
        .o_valid      (o_valid),
        .o_verdict    (out_verdict),
        .o_good_total (o_good_total),
        .o_bad_total  (o_bad_total)
    );

    assign o_sentence_ok  = out_verdict.sentence_ok;
    assign o_reject_cause = out_verdict.reject_cause;
    assign o_computed_sum = out_verdict.computed_sum;
    assign o_received_sum = out_verdict.received_sum;

endmodule
